### rtl/wspe_pkg.sv
// wspe_pkg: shared types and constants for the WS2812 SPI pixel encoder.
// Used by every module under rtl/. No dependencies.
`default_nettype none
package wspe_pkg;

    localparam int PAD_WORDS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int PIXEL_WORDS = 12;

    localparam logic [1:0] CFG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] CFG_ONE_PAT = 2'd1;
    localparam logic [1:0] CFG_ZERO_PAT = 2'd2;

    typedef struct packed {
        logic [6:0] pct;
        logic [7:0] one_pat;
        logic [7:0] zero_pat;
    } wspe_cfg_t;

    typedef struct packed {
        logic [23:0] stream;
        logic        frm_start;
        logic        frm_end;
    } wspe_item_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } wspe_qstat_t;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_PIX,
        PH_TRAIL
    } wspe_phase_t;

endpackage
`default_nettype wire

### rtl/wspe_front.sv
// wspe_front: accepts pixels, scales each channel by brightness percent.
// One register stage (products); the divide by 100 via reciprocal runs on the way
// into the queue. Uses wspe_pkg.
`default_nettype none
module wspe_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         red,
    input  wire logic [7:0]         green,
    input  wire logic [7:0]         blue,
    input  wire logic               frame_start,
    input  wire logic               frame_end,
    input  wire logic [6:0]         pct,
    input  wire logic               q_full,
    output logic                    push,
    output wspe_pkg::wspe_item_t    item
);
    import wspe_pkg::*;

    localparam logic [27:0] DIV100_MUL = 28'd5243;

    function automatic logic [7:0] div100_sat(input logic [14:0] x);
        logic [27:0] m;
        logic [8:0]  q;
        m = 28'(x) * DIV100_MUL;
        q = m[27:19];
        return (q > 9'd255) ? 8'hFF : q[7:0];
    endfunction

    logic        s1_valid_reg;
    logic [14:0] prod_r_reg;
    logic [14:0] prod_g_reg;
    logic [14:0] prod_b_reg;
    logic        start_reg;
    logic        end_reg;
    logic        accept;

    assign push     = s1_valid_reg && !q_full;
    assign in_stall = s1_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_r_reg <= {7'd0, red} * {8'd0, pct};
            prod_g_reg <= {7'd0, green} * {8'd0, pct};
            prod_b_reg <= {7'd0, blue} * {8'd0, pct};
            start_reg  <= frame_start;
            end_reg    <= frame_end;
        end
    end

    always_comb
    begin
        item.stream    = {div100_sat(prod_g_reg), div100_sat(prod_r_reg),
                          div100_sat(prod_b_reg)};
        item.frm_start = start_reg;
        item.frm_end   = end_reg;
    end

endmodule
`default_nettype wire

### rtl/wspe_fifo.sv
// wspe_fifo: short word queue between the front and back sections.
// Register array with count. Uses wspe_pkg.
`default_nettype none
module wspe_fifo #(
    parameter int DEPTH = wspe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr,
    input  wspe_pkg::wspe_item_t      wdata,
    input  wire logic                 rd,
    output wspe_pkg::wspe_item_t      rdata,
    output wspe_pkg::wspe_qstat_t     stat
);
    import wspe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wspe_item_t       mem [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign stat.full      = (count_reg == CNT_W'(DEPTH));
    assign stat.not_empty = (count_reg != '0);
    assign do_wr          = wr && !stat.full;
    assign do_rd          = rd && stat.not_empty;
    assign rdata          = mem[rptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= bump(wptr_reg);
            end
            if (do_rd)
            begin
                rptr_reg <= bump(rptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

### rtl/wspe_back.sv
// wspe_back: word serializer; emits reset words and 12 pattern words per pixel.
// Sequencer plus output register. Uses wspe_pkg.
`default_nettype none
module wspe_back #(
    parameter int PAD_WORDS = wspe_pkg::PAD_WORDS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wspe_pkg::wspe_cfg_t     cfg,
    input  wspe_pkg::wspe_item_t    item,
    input  wire logic               item_valid,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [15:0]             spi_word,
    output logic                    run_last,
    output logic                    frame_last
);
    import wspe_pkg::*;

    localparam bit HAS_PAD = (PAD_WORDS > 0);
    localparam int CNT_MAX = (PAD_WORDS > PIXEL_WORDS) ? PAD_WORDS : PIXEL_WORDS;
    localparam int CNT_W = $clog2(CNT_MAX);
    localparam logic [CNT_W-1:0] PAD_LAST = CNT_W'(HAS_PAD ? PAD_WORDS - 1 : 0);
    localparam logic [CNT_W-1:0] PIX_LAST = CNT_W'(PIXEL_WORDS - 1);

    wspe_phase_t      phase_reg, phase_next;
    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [23:0]      stream_reg, stream_next;
    logic             end_reg, end_next;

    logic             out_valid_reg;
    logic [15:0]      word_reg, word_next;
    logic             run_reg, run_next;
    logic             frm_reg, frm_next;

    logic             emit;
    logic             fin_item;

    assign emit       = busy_reg && (!out_valid_reg || !out_stall);
    assign out_valid  = out_valid_reg;
    assign spi_word   = word_reg;
    assign run_last   = run_reg;
    assign frame_last = frm_reg;

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        stream_next = stream_reg;
        end_next    = end_reg;
        fin_item    = 1'b0;
        if (emit)
        begin
            unique case (phase_reg)
                PH_LEAD:
                begin
                    if (cnt_reg == PAD_LAST)
                    begin
                        phase_next = PH_PIX;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                PH_PIX:
                begin
                    stream_next = {stream_reg[21:0], 2'b00};
                    if (cnt_reg == PIX_LAST)
                    begin
                        if (end_reg && HAS_PAD)
                        begin
                            phase_next = PH_TRAIL;
                            cnt_next   = '0;
                        end
                        else
                        begin
                            fin_item = 1'b1;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                PH_TRAIL:
                begin
                    if (cnt_reg == PAD_LAST)
                    begin
                        fin_item = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    fin_item = 1'b1;
                end
            endcase
        end
        pop = item_valid && (!busy_reg || fin_item);
        if (pop)
        begin
            busy_next   = 1'b1;
            stream_next = item.stream;
            end_next    = item.frm_end;
            phase_next  = (item.frm_start && HAS_PAD) ? PH_LEAD : PH_PIX;
            cnt_next    = '0;
        end
        else if (fin_item)
        begin
            busy_next = 1'b0;
        end
    end

    // word outputs
    always_comb
    begin
        word_next = '0;
        run_next  = 1'b0;
        frm_next  = 1'b0;
        unique case (phase_reg)
            PH_LEAD:
            begin
                word_next = '0;
            end
            PH_PIX:
            begin
                word_next[7:0]  = stream_reg[23] ? cfg.one_pat : cfg.zero_pat;
                word_next[15:8] = stream_reg[22] ? cfg.one_pat : cfg.zero_pat;
                run_next = (cnt_reg == PIX_LAST) && !(end_reg && HAS_PAD);
                frm_next = (cnt_reg == PIX_LAST) && end_reg && !HAS_PAD;
            end
            PH_TRAIL:
            begin
                run_next = (cnt_reg == PAD_LAST);
                frm_next = (cnt_reg == PAD_LAST);
            end
            default:
            begin
                word_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PIX;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stream_reg <= stream_next;
        end_reg    <= end_next;
        if (emit)
        begin
            word_reg <= word_next;
            run_reg  <= run_next;
            frm_reg  <= frm_next;
        end
    end

endmodule
`default_nettype wire

### rtl/ws2812_spi_pixel_encoder_core.sv
// ws2812_spi_pixel_encoder_core: top level; config registers, front, queue, back.
// Depends on wspe_pkg, wspe_front, wspe_fifo, wspe_back.
//
// One RGB pixel in, 16-bit SPI words out, low byte sent first. Each pixel is
// scaled by brightness_pct (floor(c*pct/100), saturating at 255) and yields 12
// words, one per clock from the back-end serializer while out_stall is low;
// frame_start adds PAD_WORDS zero words before it and frame_end PAD_WORDS
// zero words after it, so a pixel yields 12, 12+PAD_WORDS or 12+2*PAD_WORDS
// words. The front scaling stage registers the products before the queue.
// The front keeps accepting pixels into a QUEUE_DEPTH queue until it is full,
// so words stream without gaps while the queue holds pixels.
`default_nettype none
module ws2812_spi_pixel_encoder_core #(
    parameter int PAD_WORDS   = wspe_pkg::PAD_WORDS_DEF,
    parameter int QUEUE_DEPTH = wspe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    input  wire logic        frame_start,
    input  wire logic        frame_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      spi_word,
    output logic             run_last,
    output logic             frame_last
);
    import wspe_pkg::*;

    wspe_cfg_t   cfg_reg;
    wspe_item_t  front_item;
    wspe_item_t  q_item;
    wspe_qstat_t q_stat;
    logic        push;
    logic        pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pct      <= 7'd100;
            cfg_reg.one_pat  <= 8'd248;
            cfg_reg.zero_pat <= 8'd192;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BRIGHTNESS: cfg_reg.pct      <= cfg_data[6:0];
                CFG_ONE_PAT:    cfg_reg.one_pat  <= cfg_data;
                CFG_ZERO_PAT:   cfg_reg.zero_pat <= cfg_data;
                default:        cfg_reg          <= cfg_reg;
            endcase
        end
    end

    wspe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .frame_start (frame_start),
        .frame_end   (frame_end),
        .pct         (cfg_reg.pct),
        .q_full      (q_stat.full),
        .push        (push),
        .item        (front_item)
    );

    wspe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (push),
        .wdata (front_item),
        .rd    (pop),
        .rdata (q_item),
        .stat  (q_stat)
    );

    wspe_back #(
        .PAD_WORDS (PAD_WORDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (q_item),
        .item_valid (q_stat.not_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .spi_word   (spi_word),
        .run_last   (run_last),
        .frame_last (frame_last)
    );

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_stat.full)
        else $error("input stalled with queue space left");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_stat.not_empty)
        else $error("queue popped while empty");

    a_frame_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (PAD_WORDS > 0) && out_valid && frame_last |-> run_last && (spi_word == 16'd0))
        else $error("frame end word not a final zero reset word");

endmodule
`default_nettype wire
